>>> hw/rtl/cma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg
// types and fixed widths shared by the centered moving average block
// ----------------------------------------------------------------------------
package cma_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int LEN_BITS    = 6;
   localparam int SUM_BITS    = 22;
   localparam int FRAC_BITS   = 8;
   localparam int MEAN_BITS   = 24;

   // serial divider sizing
   localparam int DIV_BITS      = SUM_BITS + FRAC_BITS;
   localparam int DIV_STEP_BITS = $clog2(DIV_BITS);

   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   // magnitude limits of the mean
   localparam logic [DIV_BITS-1:0] MEAN_POS_LIMIT = DIV_BITS'((2 ** (MEAN_BITS - 1)) - 1);
   localparam logic [DIV_BITS-1:0] MEAN_NEG_LIMIT = DIV_BITS'(2 ** (MEAN_BITS - 1));
   localparam logic [MEAN_BITS-1:0] MEAN_MAX_CODE = {1'b0, {(MEAN_BITS - 1){1'b1}}};
   localparam logic [MEAN_BITS-1:0] MEAN_MIN_CODE = {1'b1, {(MEAN_BITS - 1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          end_of_series;
   } cma_req_word_type;

   typedef struct packed {
      logic signed [MEAN_BITS-1:0] mean;
      logic                        last_of_series;
   } cma_rsp_word_type;

   typedef struct packed {
      logic                       start;
      logic signed [SUM_BITS-1:0] sum;
      logic [LEN_BITS-1:0]        count;
   } cma_div_req_type;

   typedef struct packed {
      logic                        busy;
      logic                        done;
      logic signed [MEAN_BITS-1:0] mean;
   } cma_div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE
   } cma_state_type;

endpackage
`default_nettype wire

>>> hw/rtl/cma_window_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_window_ram
// sample ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module cma_window_ram
   import cma_pkg::*;
#(
   parameter int DEPTH  = 63,
   parameter int ADDR_W = 6
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output      logic signed [SAMPLE_BITS-1:0] rd_data,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic signed [SAMPLE_BITS-1:0] wr_data
);

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/cma_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cma_divider
// restoring divider, one quotient bit per cycle, signed mean with saturation
// ----------------------------------------------------------------------------
module cma_divider
   import cma_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cma_div_req_type div_req,
   output      cma_div_rsp_type div_rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [LEN_BITS-1:0]      rem_ff, rem_in;
   logic [LEN_BITS-1:0]      den_ff, den_in;
   logic [DIV_BITS-1:0]      quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;

   logic [LEN_BITS:0]        trial;
   logic                     fits;
   logic signed [DIV_BITS-1:0] scaled;
   logic [DIV_BITS-1:0]      neg_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;

      trial  = {rem_ff, quo_ff[DIV_BITS-1]};
      fits   = trial >= {1'b0, den_ff};
      scaled = {div_req.sum, {FRAC_BITS{1'b0}}};

      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = '0;
         den_in  = div_req.count;
         neg_in  = div_req.sum[SUM_BITS-1];
         zero_in = div_req.count == '0;
         quo_in  = div_req.sum[SUM_BITS-1] ? (~scaled + 1'b1) : scaled;
      end else if (busy_ff) begin
         rem_in = fits ? LEN_BITS'(trial - {1'b0, den_ff}) : trial[LEN_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // sign and clamp the quotient magnitude
   always_comb begin
      neg_full = '0 - quo_ff;
      if (zero_ff) begin
         div_rsp.mean = '0;
      end else if (neg_ff) begin
         div_rsp.mean = (quo_ff > MEAN_NEG_LIMIT) ? MEAN_MIN_CODE : neg_full[MEAN_BITS-1:0];
      end else begin
         div_rsp.mean = (quo_ff > MEAN_POS_LIMIT) ? MEAN_MAX_CODE : quo_ff[MEAN_BITS-1:0];
      end
      div_rsp.busy = busy_ff;
      div_rsp.done = done_ff;
   end

endmodule
`default_nettype wire

>>> hw/rtl/centered_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centered_moving_average
// boxcar mean centered on the sample h = (length-1)/2 positions back
// ----------------------------------------------------------------------------
// per word: acceptance, then per ring position a ram read and an update/write
// back, plus for a position that yields a mean the serial divider steps and
// the output load; an end of series word adds h flush positions after its own;
// a stalled mean word holds the next load back
// synchronous active high reset clears control, sum, counts, ring position and
// sets the length to 1; the sample ram is not cleared (no sweep, no wait)
// ----------------------------------------------------------------------------
module centered_moving_average
   import cma_pkg::*;
#(
   parameter int WINDOW_MAX = 63
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // sample words
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire cma_req_word_type    req_word,
   // mean words
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      cma_rsp_word_type    rsp_word,
   // window length register
   input  wire logic                csr_wr_en,
   input  wire logic [LEN_BITS-1:0] csr_wr_data
);

   localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   // control and running state
   cma_state_type              state_ff, state_in;
   logic [LEN_BITS-1:0]        cfg_len_ff;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [LEN_BITS-1:0]        cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]        pos_ff, pos_in;
   logic [LEN_BITS-1:0]        seen_ff, seen_in;
   logic [LEN_BITS-1:0]        flush_ff, flush_in;
   logic                       last_ff, last_in;
   logic                       has_ff, has_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload holding
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          final_ff, final_in;
   cma_rsp_word_type              rsp_word_ff, rsp_word_in;

   // effective length and half width
   logic [LEN_BITS-1:0] eff_len;
   logic [LEN_BITS-1:0] half_len;

   // ram port
   logic                          ram_rd_en;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic signed [SAMPLE_BITS-1:0] ram_rd_data;
   logic                          ram_wr_en;

   // advance arithmetic
   logic [LEN_BITS-1:0]        pos_wrap;
   logic [LEN_BITS-1:0]        pos_step;
   logic                       drop_old;
   logic signed [SUM_BITS-1:0] sum_drop;
   logic signed [SUM_BITS-1:0] sum_add;
   logic [LEN_BITS-1:0]        cnt_drop;
   logic [LEN_BITS-1:0]        cnt_add;
   logic [LEN_BITS-1:0]        seen_next;

   logic finish;
   logic slot_free;
   logic rsp_load;

   cma_div_req_type div_req;
   cma_div_rsp_type div_rsp;

   // zero reads as one, anything past the ram depth is clamped
   always_comb begin
      if (cfg_len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (int'(cfg_len_ff) > WINDOW_MAX) begin
         eff_len = LEN_BITS'(WINDOW_MAX);
      end else begin
         eff_len = cfg_len_ff;
      end
      half_len = (eff_len - 1'b1) >> 1;
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_len_ff   <= LEN_BITS'(1);
         sum_ff       <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         flush_ff     <= '0;
         last_ff      <= 1'b0;
         has_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         flush_ff     <= flush_in;
         last_ff      <= last_in;
         has_ff       <= has_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cfg_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      final_ff    <= final_in;
      rsp_word_ff <= rsp_word_in;
   end

   // sequencer: one pass through read/update per ring position
   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      flush_in  = flush_ff;
      last_in   = last_ff;
      has_in    = has_ff;
      sample_in = sample_ff;
      final_in  = final_ff;

      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      finish      = 1'b0;
      rsp_load    = 1'b0;

      pos_wrap    = (pos_ff >= eff_len) ? '0 : pos_ff;
      ram_rd_addr = ADDR_W'(pos_wrap);

      // remove the oldest sample once the window is full
      drop_old = (seen_ff >= eff_len) && (cnt_ff != '0);
      sum_drop = drop_old ? (sum_ff - SUM_BITS'(ram_rd_data)) : sum_ff;
      cnt_drop = drop_old ? (cnt_ff - 1'b1) : cnt_ff;
      sum_add  = has_ff ? (sum_drop + SUM_BITS'(sample_ff)) : sum_drop;
      cnt_add  = (has_ff && (cnt_drop != LEN_MAX)) ? (cnt_drop + 1'b1) : cnt_drop;
      pos_step = ((pos_ff + 1'b1) >= eff_len) ? '0 : (pos_ff + 1'b1);
      seen_next = (seen_ff < eff_len) ? (seen_ff + 1'b1) : seen_ff;

      div_req.start = 1'b0;
      div_req.sum   = sum_add;
      div_req.count = cnt_add;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_word.sample;
               last_in   = req_word.end_of_series;
               flush_in  = req_word.end_of_series ? half_len : '0;
               has_in    = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            pos_in    = pos_wrap;
            ram_rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_wr_en = has_ff;
            sum_in    = sum_add;
            cnt_in    = cnt_add;
            pos_in    = pos_step;
            seen_in   = seen_next;
            // the final position of an end of series word carries the flag
            final_in  = last_ff && (flush_ff == '0);
            if (seen_next > half_len) begin
               div_req.start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               finish = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done && slot_free) begin
               rsp_load = 1'b1;
               finish   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // position done: run a flush position or wind up the word
      if (finish) begin
         if (flush_ff != '0) begin
            flush_in = flush_ff - 1'b1;
            has_in   = 1'b0;
            state_in = ST_READ;
         end else begin
            state_in = ST_IDLE;
            if (last_ff) begin
               sum_in  = '0;
               cnt_in  = '0;
               pos_in  = '0;
               seen_in = '0;
            end
         end
      end
   end

   // output register, free again once the word is taken
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.mean           = div_rsp.mean;
         rsp_word_in.last_of_series = final_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   cma_window_ram #(
      .DEPTH  (WINDOW_MAX),
      .ADDR_W (ADDR_W)
   ) u_window_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(pos_ff)),
      .wr_data (sample_ff)
   );

   cma_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ram data is only used the cycle after its read
   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(state_ff) == ST_READ))
      else $error("update without a preceding ram read");

   // ring position addresses an existing ram entry
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (int'(pos_ff) < WINDOW_MAX))
      else $error("ring position outside the ram");

   // a divide is never started over one still running
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   // an accepted word goes straight to the ram read
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_READ))
      else $error("accepted word did not start a ram read");

   // the output word is loaded only over a free slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> !rsp_stall)
      else $error("pending mean word overwritten");

endmodule
`default_nettype wire
